// ----- hw/rtl/text_console_cell_writer_defines.svh -----
// Assertion macros shared by the text console cell writer modules.
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that holds outside reset.
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCCW_ASSERT(lbl, prop, msg)
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hw/rtl/tccw_pkg.sv -----
// Shared constants, codes and control types of the text console cell writer.
package tccw_pkg;

  // Store geometry.
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int TAB_STEP = 4;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;

  // Port field widths.
  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int NCOLS_W   = 8;
  localparam int NROWS_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;
  localparam int CELL_W    = CHAR_W + COLOR_W;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;

  // Register reset values.
  localparam logic [COLOR_W-1:0] COLOR_RST = 8'd15;
  localparam logic [NCOLS_W-1:0] COLS_RST  = 8'd80;
  localparam logic [NROWS_W-1:0] ROWS_RST  = 7'd25;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic copy_step;
    logic blank_step;
    logic clear_step;
    logic cnt_clear;
    logic load_out;
  } tccw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              scroll_req;
    logic              copy_done;
    logic              blank_last;
    logic              clear_last;
  } tccw_sts_t;

endpackage

// ----- hw/rtl/tccw_datapath.sv -----
// Datapath: registers, cursor logic, cell store and result registers.
module tccw_datapath import tccw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [CHAR_W-1:0]    in_char_byte,
  input  logic                 in_last_byte,
  input  logic [COL_W-1:0]     in_target_col,
  input  logic [ROW_W-1:0]     in_target_row,
  input  tccw_cmd_t            cmd,
  output tccw_sts_t            sts,
  output logic [COL_W-1:0]     out_cursor_col,
  output logic [ROW_W-1:0]     out_cursor_row,
  output logic                 out_scrolled,
  output logic                 out_write_done,
  output logic [CHAR_W-1:0]    out_cell_char,
  output logic [COLOR_W-1:0]   out_cell_color
);

  localparam int CA_W = NCOLS_W + 1;
  localparam int RA_W = NROWS_W + 1;

  // Configuration and cursor registers.
  logic [COLOR_W-1:0] color_r;
  logic [NCOLS_W-1:0] ncols_r;
  logic [NROWS_W-1:0] nrows_r;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;

  // Item registers.
  logic [KIND_W-1:0] kind_r;
  logic [CHAR_W-1:0] chr_r;
  logic              last_r;
  logic [COL_W-1:0]  tcol_r;
  logic [ROW_W-1:0]  trow_r;

  // Work registers.
  logic              scrolled_r, scrolled_nxt;
  logic              read_ok_r, read_ok_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic              pend_r;
  logic [ADDR_W-1:0] dst_r;
  logic [CELL_W-1:0] rd_r;
  logic [CELL_W-1:0] mem [DEPTH];

  // Result registers.
  logic [COL_W-1:0]   res_col_r;
  logic [ROW_W-1:0]   res_row_r;
  logic               res_scrolled_r;
  logic               res_done_r;
  logic [CHAR_W-1:0]  res_char_r;
  logic [COLOR_W-1:0] res_color_r;

  // Cursor arithmetic.
  logic [NCOLS_W-1:0] cols_eff;
  logic [NROWS_W-1:0] rows_eff;
  logic [COL_W-1:0]   c0, tcol_sat;
  logic [ROW_W-1:0]   r0, trow_sat, last_row;
  logic               is_nl, is_tab, is_esc, is_print, wrap, scroll_req;
  logic [CA_W-1:0]    c_a, c_b;
  logic [RA_W-1:0]    r_a, r_b;
  logic [ADDR_W-1:0]  copy_len;
  logic               copy_more;
  logic [CELL_W-1:0]  blank;

  // Memory port signals.
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  // Effective geometry, saturated to the store size, with zero taken as one.
  always_comb begin
    if (ncols_r == '0) begin
      cols_eff = NCOLS_W'(1);
    end else if (ncols_r > NCOLS_W'(MAX_COLS)) begin
      cols_eff = NCOLS_W'(MAX_COLS);
    end else begin
      cols_eff = ncols_r;
    end
    if (nrows_r == '0) begin
      rows_eff = NROWS_W'(1);
    end else if (nrows_r > NROWS_W'(MAX_ROWS)) begin
      rows_eff = NROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = nrows_r;
    end
  end

  assign last_row = ROW_W'(rows_eff - NROWS_W'(1));
  assign blank    = {color_r, CH_SPACE};

  // Saturated cursor and targets.
  assign c0 = (NCOLS_W'(cur_col_r) >= cols_eff) ? COL_W'(cols_eff - NCOLS_W'(1)) : cur_col_r;
  assign r0 = (NROWS_W'(cur_row_r) >= rows_eff) ? last_row : cur_row_r;
  assign tcol_sat = (NCOLS_W'(tcol_r) >= cols_eff) ? COL_W'(cols_eff - NCOLS_W'(1)) : tcol_r;
  assign trow_sat = (NROWS_W'(trow_r) >= rows_eff) ? last_row : trow_r;

  // Byte rule and wrap.
  always_comb begin
    is_nl    = (chr_r == CH_NL) || (chr_r == CH_CR);
    is_tab   = (chr_r == CH_TAB);
    is_esc   = (chr_r == CH_ESC);
    is_print = !is_nl && !is_tab && !is_esc;
    if (is_nl) begin
      c_a = '0;
    end else if (is_tab) begin
      c_a = CA_W'(c0) + CA_W'(TAB_STEP);
    end else if (is_esc) begin
      c_a = CA_W'(c0);
    end else begin
      c_a = CA_W'(c0) + CA_W'(1);
    end
    r_a  = RA_W'(r0) + RA_W'(is_nl);
    wrap = (c_a >= CA_W'(cols_eff));
    c_b  = wrap ? '0 : c_a;
    r_b  = r_a + RA_W'(wrap);
    scroll_req = (kind_r == KIND_WRITE) && (r_b >= RA_W'(rows_eff));
  end

  // Next cursor and flags for the item under way.
  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    scrolled_nxt = scrolled_r;
    read_ok_nxt  = read_ok_r;
    if (cmd.exec) begin
      scrolled_nxt = 1'b0;
      read_ok_nxt  = 1'b0;
      case (kind_r)
        KIND_WRITE: begin
          cur_col_nxt  = c_b[COL_W-1:0];
          cur_row_nxt  = scroll_req ? last_row : r_b[ROW_W-1:0];
          scrolled_nxt = scroll_req;
        end
        KIND_SET: begin
          cur_col_nxt = tcol_sat;
          cur_row_nxt = trow_sat;
        end
        KIND_CLEAR: begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
        end
        KIND_READ: begin
          read_ok_nxt = ({1'b0, tcol_r} < (COL_W + 1)'(MAX_COLS)) &&
                        ({1'b0, trow_r} < (ROW_W + 1)'(MAX_ROWS));
        end
        default: begin
          read_ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // Scroll copy runs over every row below the top one.
  assign copy_len  = {ROW_W'(rows_eff - NROWS_W'(1)), COL_W'(0)};
  assign copy_more = (cnt_r < copy_len);

  // Single write port and single read port of the store.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd.exec && (kind_r == KIND_WRITE) && is_print) begin
      mem_we    = 1'b1;
      mem_waddr = {r0, c0};
      mem_wdata = {color_r, chr_r};
    end else if (cmd.copy_step && pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = dst_r;
      mem_wdata = rd_r;
    end else if (cmd.blank_step) begin
      mem_we    = 1'b1;
      mem_waddr = {last_row, cnt_r[COL_W-1:0]};
      mem_wdata = blank;
    end else if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = blank;
    end
    if (cmd.exec && (kind_r == KIND_READ)) begin
      mem_re    = 1'b1;
      mem_raddr = {trow_r, tcol_r};
    end else if (cmd.copy_step && copy_more) begin
      mem_re    = 1'b1;
      mem_raddr = cnt_r + ADDR_W'(MAX_COLS);
    end
  end

  // Cell store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RST;
      ncols_r <= COLS_RST;
      nrows_r <= ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR: color_r <= cfg_wdata[COLOR_W-1:0];
        CFG_COLS:  ncols_r <= cfg_wdata[NCOLS_W-1:0];
        CFG_ROWS:  nrows_r <= cfg_wdata[NROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Cursor, flags, sweep counter and copy pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      scrolled_r <= 1'b0;
      read_ok_r  <= 1'b0;
      pend_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      scrolled_r <= scrolled_nxt;
      read_ok_r  <= read_ok_nxt;
      pend_r     <= cmd.copy_step && copy_more;
      if (cmd.cnt_clear) begin
        cnt_r <= '0;
      end else if ((cmd.copy_step && copy_more) || cmd.blank_step || cmd.clear_step) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
    end
  end

  // Item capture, copy destination and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      chr_r  <= in_char_byte;
      last_r <= in_last_byte;
      tcol_r <= in_target_col;
      trow_r <= in_target_row;
    end
    if (cmd.copy_step && copy_more) begin
      dst_r <= cnt_r;
    end
    if (cmd.load_out) begin
      res_col_r      <= cur_col_r;
      res_row_r      <= cur_row_r;
      res_scrolled_r <= scrolled_r;
      res_done_r     <= (kind_r == KIND_WRITE) && last_r;
      res_char_r     <= read_ok_r ? rd_r[CHAR_W-1:0] : '0;
      res_color_r    <= read_ok_r ? rd_r[CELL_W-1:CHAR_W] : '0;
    end
  end

  // Status to the controller.
  assign sts.kind       = kind_r;
  assign sts.scroll_req = scroll_req;
  assign sts.copy_done  = !copy_more && !pend_r;
  assign sts.blank_last = (cnt_r == ADDR_W'(MAX_COLS - 1));
  assign sts.clear_last = (cnt_r == ADDR_W'(DEPTH - 1));

  assign out_cursor_col = res_col_r;
  assign out_cursor_row = res_row_r;
  assign out_scrolled   = res_scrolled_r;
  assign out_write_done = res_done_r;
  assign out_cell_char  = res_char_r;
  assign out_cell_color = res_color_r;

endmodule

// ----- hw/rtl/tccw_ctrl.sv -----
// Controller state machine: item sequencing, store sweeps and result handshake.
`include "text_console_cell_writer_defines.svh"

module tccw_ctrl import tccw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tccw_sts_t sts,
  output tccw_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_BLANK  = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_FINISH) && out_free);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load_item = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.cnt_clear = 1'b1;
        if (sts.kind == KIND_CLEAR) begin
          state_nxt = S_CLEAR;
        end else if (sts.scroll_req) begin
          state_nxt = S_COPY;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) begin
          cmd.cnt_clear = 1'b1;
          state_nxt     = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (sts.blank_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = in_valid ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // The execute step never repeats without a new item.
  `TCCW_ASSERT(a_exec_once, (state_r == S_EXEC) |=> (state_r != S_EXEC), "execute step repeated")
  // A new item is taken only in the idle state or when the result register is free.
  `TCCW_ASSERT(a_accept_room, cmd.load_item |-> ((state_r == S_IDLE) || out_free), "item taken while result blocked")
  // Only a clear item sweeps the whole store.
  `TCCW_ASSERT(a_clear_kind, (state_r == S_CLEAR) |-> (sts.kind == KIND_CLEAR), "clear sweep for another kind")
  // Scrolling belongs to byte writes only.
  `TCCW_ASSERT(a_scroll_kind, ((state_r == S_COPY) || (state_r == S_BLANK)) |-> (sts.kind == KIND_WRITE), "scroll for another kind")
  // Reset leaves no result pending.
  `TCCW_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

// ----- hw/rtl/text_console_cell_writer.sv -----
// Text console cell writer: 8192-cell character store with cursor, scroll and clear.
//
// Input channel (in_valid/in_ready) takes one item: write a byte at the cursor,
// set the cursor, clear the screen, or read one cell. Every item gives exactly
// one result on the output channel (out_valid/out_ready): the cursor after the
// item, a scroll flag, the write-done echo and, for a read, the cell contents.
// An item without a sweep has an execute step that updates the cursor and does
// the single store write or read, then a step that loads the result register;
// that step waits while a result is held and not taken, and the next item can
// be taken in it. A scroll copies each row below the top one up, a cell per
// cycle through the one-write, one-read port of the store, and then blanks the
// last row; a clear writes blank to all 8192 cells, one store write each.
// The result register lets the next item enter while a result waits; a stalled
// receiver holds the block once a second result is finished.
// Reset (rst_n, synchronous) returns the cursor to the top left corner, sets the
// color to 15 and the geometry to 80 by 25; the store is undefined until cleared.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once.
module text_console_cell_writer import tccw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [CHAR_W-1:0]    in_char_byte,
  input  logic                 in_last_byte,
  input  logic [COL_W-1:0]     in_target_col,
  input  logic [ROW_W-1:0]     in_target_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COL_W-1:0]     out_cursor_col,
  output logic [ROW_W-1:0]     out_cursor_row,
  output logic                 out_scrolled,
  output logic                 out_write_done,
  output logic [CHAR_W-1:0]    out_cell_char,
  output logic [COLOR_W-1:0]   out_cell_color
);

  tccw_cmd_t cmd;
  tccw_sts_t sts;

  // Sequencing and handshakes.
  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store, cursor and result registers.
  tccw_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_kind),
    .in_char_byte   (in_char_byte),
    .in_last_byte   (in_last_byte),
    .in_target_col  (in_target_col),
    .in_target_row  (in_target_row),
    .cmd            (cmd),
    .sts            (sts),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled),
    .out_write_done (out_write_done),
    .out_cell_char  (out_cell_char),
    .out_cell_color (out_cell_color)
  );

endmodule
